/* design/jpsp_pkg.sv */
// ----------------------------------------------------------------------------
// jpsp_pkg
// Shared types and constants for the gamepad serial poll responder.
// ----------------------------------------------------------------------------
package jpsp_pkg;

   localparam int OpcodeWidth  = 3;
   localparam int WriteWidth   = 14;
   localparam int ButtonWidth  = 16;
   localparam int ReadWidth    = 16;
   localparam int ReplyDepth   = 4;
   localparam int PosWidth     = 3;

   typedef enum logic [OpcodeWidth-1:0] {
      OP_WR_DATA = 3'd0,
      OP_RD_DATA = 3'd1,
      OP_WR_CTRL = 3'd2,
      OP_RD_STAT = 3'd3,
      OP_RD_CTRL = 3'd4
   } opcode_type;

   // poll handshake bytes
   localparam logic [7:0] BYTE_START = 8'h01;
   localparam logic [7:0] BYTE_POLL  = 8'h42;
   localparam logic [7:0] PAD_ID     = 8'h5A;
   localparam logic [7:0] BYTE_IDLE  = 8'hFF;

   localparam logic [ReadWidth-1:0] STATUS_BASE = 16'h0005;

   // handshake phases
   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_POLL  = 2'd1;
   localparam logic [1:0] PHASE_CMD   = 2'd2;
   localparam logic [1:0] PHASE_REPLY = 2'd3;

   // control word bits
   localparam int CTRL_SELECT = 0;
   localparam int CTRL_TX_EN  = 1;

   typedef struct packed {
      logic [OpcodeWidth-1:0] opcode;
      logic [WriteWidth-1:0]  write_value;
      logic [ButtonWidth-1:0] buttons;
   } req_item_type;

   typedef struct packed {
      logic                 valid;
      logic [ReadWidth-1:0] value;
   } result_type;

endpackage

/* design/jpsp_if.sv */
// ----------------------------------------------------------------------------
// jpsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface jpsp_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [13:0] write_value;
   logic [15:0] buttons;

   modport source (output valid, output opcode, output write_value, output buttons,
                   input ready);
   modport sink   (input valid, input opcode, input write_value, input buttons,
                   output ready);
endinterface

interface jpsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] read_value;

   modport source (output valid, output read_value, input ready);
   modport sink   (input valid, input read_value, output ready);
endinterface

/* design/jpsp_in_stage.sv */
// ----------------------------------------------------------------------------
// jpsp_in_stage
// Input register: captures one request beat and holds it until it is issued.
// ----------------------------------------------------------------------------
module jpsp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   jpsp_req_if.sink              req_ch,
   input  logic                  issue,
   output logic                  item_valid,
   output jpsp_pkg::req_item_type item
);
   import jpsp_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   assign req_ch.ready = !valid_ff || issue;
   assign valid_in     = req_ch.valid || (valid_ff && !issue);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         item_ff <= '{opcode: req_ch.opcode, write_value: req_ch.write_value,
                      buttons: req_ch.buttons};
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* design/jpsp_core.sv */
// ----------------------------------------------------------------------------
// jpsp_core
// Port state and the single-pass update for one issued access.
// ----------------------------------------------------------------------------
module jpsp_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   issue,
   input  jpsp_pkg::req_item_type item,
   output jpsp_pkg::result_type   result
);
   import jpsp_pkg::*;

   logic [WriteWidth-1:0] ctrl_ff,  ctrl_in;
   logic [1:0]            phase_ff, phase_in;
   logic [PosWidth-1:0]   pos_ff,   pos_in;
   logic [PosWidth-1:0]   len_ff,   len_in;
   logic                  rx_rdy_ff, rx_rdy_in;
   logic                  ack_ff,   ack_in;
   logic [7:0]            reply_ff [ReplyDepth];
   logic [7:0]            reply_in [ReplyDepth];
   logic                  reply_we;

   opcode_type          op;
   logic [7:0]          wr_byte;
   logic [PosWidth-1:0] pos_inc;

   assign op      = opcode_type'(item.opcode);
   assign wr_byte = item.write_value[7:0];
   assign pos_inc = pos_ff + PosWidth'(1);

   always_comb begin
      ctrl_in   = ctrl_ff;
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      rx_rdy_in = rx_rdy_ff;
      ack_in    = ack_ff;
      reply_in  = reply_ff;
      reply_we  = 1'b0;
      result    = '{valid: 1'b0, value: '0};

      case (op)
         OP_WR_DATA: begin
            if (ctrl_ff[CTRL_TX_EN]) begin
               if (wr_byte == BYTE_START) begin
                  phase_in    = PHASE_POLL;
                  reply_we    = 1'b1;
                  reply_in[0] = BYTE_IDLE;
                  len_in      = PosWidth'(1);
                  pos_in      = '0;
                  rx_rdy_in   = 1'b1;
               end else if (phase_ff == PHASE_POLL && wr_byte == BYTE_POLL) begin
                  phase_in = PHASE_CMD;
               end else if (phase_ff == PHASE_CMD) begin
                  phase_in = PHASE_REPLY;
               end else if (phase_ff == PHASE_REPLY) begin
                  reply_we    = 1'b1;
                  reply_in[0] = PAD_ID;
                  reply_in[1] = item.buttons[7:0];
                  reply_in[2] = item.buttons[15:8];
                  reply_in[3] = BYTE_IDLE;
                  len_in      = PosWidth'(ReplyDepth);
                  pos_in      = '0;
                  rx_rdy_in   = 1'b1;
                  phase_in    = PHASE_IDLE;
               end else begin
                  reply_we    = 1'b1;
                  reply_in[0] = BYTE_IDLE;
                  len_in      = PosWidth'(1);
                  pos_in      = '0;
                  rx_rdy_in   = 1'b1;
               end
            end
         end
         OP_RD_DATA: begin
            result.valid = 1'b1;
            if (!rx_rdy_ff) begin
               result.value = {8'h00, BYTE_IDLE};
            end else if (pos_ff >= len_ff || pos_ff[PosWidth-1]) begin
               // reply ran dry
               rx_rdy_in    = 1'b0;
               result.value = {8'h00, BYTE_IDLE};
            end else begin
               result.value = {8'h00, reply_ff[pos_ff[1:0]]};
               pos_in       = pos_inc;
               if (pos_inc >= len_ff) begin
                  rx_rdy_in = 1'b0;
                  ack_in    = 1'b1;
               end
            end
         end
         OP_WR_CTRL: begin
            ctrl_in = item.write_value;
            if (!item.write_value[CTRL_SELECT]) begin
               phase_in = PHASE_IDLE;
               pos_in   = '0;
               len_in   = '0;
               ack_in   = 1'b0;
            end
         end
         OP_RD_STAT: begin
            result.valid = 1'b1;
            result.value = STATUS_BASE | {13'd0, ack_ff, rx_rdy_ff, 1'b0};
         end
         OP_RD_CTRL: begin
            result.valid = 1'b1;
            result.value = {2'b00, ctrl_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff   <= '0;
         phase_ff  <= PHASE_IDLE;
         pos_ff    <= '0;
         len_ff    <= '0;
         rx_rdy_ff <= 1'b0;
         ack_ff    <= 1'b0;
      end else if (issue) begin
         ctrl_ff   <= ctrl_in;
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         rx_rdy_ff <= rx_rdy_in;
         ack_ff    <= ack_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue && reply_we) begin
         reply_ff <= reply_in;
      end
   end

endmodule

/* design/jpsp_out_stage.sv */
// ----------------------------------------------------------------------------
// jpsp_out_stage
// Result register driving the response channel.
// ----------------------------------------------------------------------------
module jpsp_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  jpsp_pkg::result_type result,
   output logic                 busy,
   jpsp_rsp_if.source           rsp_ch
);
   import jpsp_pkg::*;

   logic                 valid_ff, valid_in;
   logic [ReadWidth-1:0] value_ff;

   assign valid_in = (load && result.valid) || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         value_ff <= result.value;
      end
   end

   // register cannot take a new beat while an old one is stalled
   assign busy              = valid_ff && !rsp_ch.ready;
   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.read_value = value_ff;

endmodule

/* design/joypad_serial_poll_responder.sv */
// ----------------------------------------------------------------------------
// joypad_serial_poll_responder
// Gamepad port register model answering data, control and status accesses.
// ----------------------------------------------------------------------------
// One access is taken every cycle while the response side is not stalled. An
// accepted beat is held in the input register and is applied to the port
// state in a single combinational pass when it issues. A read's result is
// captured in the result register, which drives the response channel.
// Writes give no response. Throughput is bounded only by the response side.
// A stalled response holds the input register, after which requests back up.
module joypad_serial_poll_responder (
   input  logic      clock,
   input  logic      reset,
   jpsp_req_if.sink  req_ch,
   jpsp_rsp_if.source rsp_ch
);
   import jpsp_pkg::*;

   logic         item_valid;
   logic         issue;
   logic         out_busy;
   req_item_type item;
   result_type   result;

   assign issue = item_valid && !out_busy;

   jpsp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .issue      (issue),
      .item_valid (item_valid),
      .item       (item)
   );

   jpsp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .item   (item),
      .result (result)
   );

   jpsp_out_stage u_out_stage (
      .clock  (clock),
      .reset  (reset),
      .load   (issue),
      .result (result),
      .busy   (out_busy),
      .rsp_ch (rsp_ch)
   );

endmodule

/* bench/joypad_serial_poll_responder_tb.sv */
// ----------------------------------------------------------------------------
// joypad_serial_poll_responder_tb
// Drives random and directed register accesses into the gamepad port and
// checks every read against a cycle-free model of the poll handshake, the
// reply buffer and the status and control words.
// ----------------------------------------------------------------------------
module joypad_serial_poll_responder_tb;
   import jpsp_pkg::*;

   localparam int StallLimit  = 500;
   localparam int TargetItems = 1050;

   // Model of the port: handshake phase, reply buffer, status flags, and the
   // reads it still owes.
   class poll_scoreboard;
      logic [WriteWidth-1:0] ctrl;
      logic [1:0]            phase;
      logic [7:0]            reply [ReplyDepth];
      logic [PosWidth-1:0]   pos;
      logic [PosWidth-1:0]   len;
      bit                    rx_ready;
      bit                    ack;
      logic [ReadWidth-1:0]  expected_reads [$];
      int                    errors;

      function new();
         ctrl     = '0;
         phase    = PHASE_IDLE;
         foreach (reply[i]) reply[i] = '0;
         pos      = '0;
         len      = '0;
         rx_ready = 1'b0;
         ack      = 1'b0;
         errors   = 0;
      endfunction

      function void queue_idle();
         reply[0] = BYTE_IDLE;
         len      = 3'd1;
         pos      = '0;
         rx_ready = 1'b1;
      endfunction

      function void note_request(opcode_type op, logic [WriteWidth-1:0] wv,
                                 logic [ButtonWidth-1:0] btn);
         logic [7:0] b;
         logic [7:0] rd;
         b = wv[7:0];
         case (op)
            OP_WR_DATA: begin
               if (ctrl[CTRL_TX_EN]) begin
                  if (b == BYTE_START) begin
                     phase = PHASE_POLL;
                     queue_idle();
                  end else if (phase == PHASE_POLL && b == BYTE_POLL) begin
                     phase = PHASE_CMD;
                  end else if (phase == PHASE_CMD) begin
                     phase = PHASE_REPLY;
                  end else if (phase == PHASE_REPLY) begin
                     reply[0] = PAD_ID;
                     reply[1] = btn[7:0];
                     reply[2] = btn[15:8];
                     reply[3] = BYTE_IDLE;
                     len      = 3'd4;
                     pos      = '0;
                     rx_ready = 1'b1;
                     phase    = PHASE_IDLE;
                  end else begin
                     queue_idle();
                  end
               end
            end
            OP_RD_DATA: begin
               rd = BYTE_IDLE;
               if (rx_ready) begin
                  if (pos >= len || pos >= 3'd4) begin
                     rx_ready = 1'b0;
                  end else begin
                     rd  = reply[pos[1:0]];
                     pos = pos + 3'd1;
                     if (pos >= len) begin
                        rx_ready = 1'b0;
                        ack      = 1'b1;
                     end
                  end
               end
               expected_reads.push_back({8'h00, rd});
            end
            OP_WR_CTRL: begin
               ctrl = wv;
               // deselect drops the handshake but leaves receive-ready alone
               if (!wv[CTRL_SELECT]) begin
                  phase = PHASE_IDLE;
                  pos   = '0;
                  len   = '0;
                  ack   = 1'b0;
               end
            end
            OP_RD_STAT: expected_reads.push_back(STATUS_BASE | {13'd0, ack, rx_ready, 1'b0});
            OP_RD_CTRL: expected_reads.push_back({2'b00, ctrl});
            default: ;
         endcase
      endfunction

      function void check_response(logic [ReadWidth-1:0] got);
         logic [ReadWidth-1:0] want;
         if (expected_reads.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            errors++;
         end else begin
            want = expected_reads.pop_front();
            if (got !== want) begin
               $display("%0t: read_value mismatch, expected %h, actual %h", $time, want, got);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_reads.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   jpsp_req_if req_ch ();
   jpsp_rsp_if rsp_ch ();

   joypad_serial_poll_responder u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #4 clock = ~clock;

   poll_scoreboard sb = new();
   bit calm;
   int applied_count;
   int idle_cycles = 0;

   function automatic logic [WriteWidth-1:0] rand_word();
      return WriteWidth'($urandom_range(0, 16383));
   endfunction

   function automatic logic [ButtonWidth-1:0] rand_buttons();
      return ButtonWidth'($urandom_range(0, 65535));
   endfunction

   // one access beat; the previous beat's valid is held when there is no gap
   task automatic send_access(input opcode_type op, input logic [WriteWidth-1:0] wv,
                              input logic [ButtonWidth-1:0] btn);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      applied_count++;
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= op;
      req_ch.write_value <= wv;
      req_ch.buttons     <= btn;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(op, wv, btn);
   endtask

   function automatic logic [WriteWidth-1:0] data_word(input logic [7:0] b);
      logic [WriteWidth-1:0] wv;
      wv      = rand_word();
      wv[7:0] = b;
      return wv;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 3))
         0:       return BYTE_START;
         1:       return BYTE_POLL;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_random();
      opcode_type op;
      logic [WriteWidth-1:0] wv;
      op = opcode_type'($urandom_range(0, 4));
      wv = rand_word();
      if (op == OP_WR_DATA && $urandom_range(0, 1)) wv[7:0] = pick_byte();
      send_access(op, wv, rand_buttons());
   endtask

   // well-formed poll with random content and stray reads mixed in
   task automatic poll_sequence();
      logic [WriteWidth-1:0] wv;
      int n_reads;
      if (sb.ctrl[1:0] != 2'b11 || $urandom_range(0, 5) == 0) begin
         wv      = rand_word();
         wv[1:0] = 2'b11;
         send_access(OP_WR_CTRL, wv, rand_buttons());
      end
      send_access(OP_WR_DATA, data_word(BYTE_START), rand_buttons());
      if ($urandom_range(0, 1)) send_access(OP_RD_DATA, data_word(8'h00), rand_buttons());
      send_access(OP_WR_DATA, data_word(BYTE_POLL), rand_buttons());
      if ($urandom_range(0, 3) == 0) send_access(OP_RD_STAT, data_word(8'h00), rand_buttons());
      send_access(OP_WR_DATA, data_word(8'($urandom_range(0, 255))), rand_buttons());
      send_access(OP_WR_DATA, data_word(8'($urandom_range(0, 255))), rand_buttons());
      n_reads = $urandom_range(3, 6);
      repeat (n_reads) begin
         if ($urandom_range(0, 4) == 0)
            send_access(OP_RD_STAT, data_word(8'h00), rand_buttons());
         send_access(OP_RD_DATA, data_word(8'h00), rand_buttons());
      end
   endtask

   // response side: random back-pressure, every beat checked in order
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 17);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid || !rsp_ch.ready);
         sb.check_response(rsp_ch.read_value);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("%0t: no beat accepted for %0d cycles", $time, StallLimit);
            $display("joypad_serial_poll_responder_tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      int kind;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.opcode      <= OP_WR_DATA;
      req_ch.write_value <= '0;
      req_ch.buttons     <= '0;
      calm               = 1'b0;
      applied_count      = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values, extremes of the control word, a full poll,
      // a wrong second byte, exhausted reply and deselect with data pending
      send_access(OP_RD_STAT, 14'h0000, 16'h0000);
      send_access(OP_RD_CTRL, 14'h0000, 16'h0000);
      send_access(OP_RD_DATA, 14'h0000, 16'h0000);
      send_access(OP_WR_DATA, 14'h0001, 16'h0000);   // transmit off: dropped
      send_access(OP_WR_CTRL, 14'h3FFF, 16'hFFFF);
      send_access(OP_RD_CTRL, 14'h0000, 16'h0000);
      send_access(OP_WR_CTRL, 14'h0003, 16'h0000);
      send_access(OP_WR_DATA, 14'h3F01, 16'h0000);
      send_access(OP_RD_STAT, 14'h0000, 16'h0000);
      send_access(OP_RD_DATA, 14'h0000, 16'h0000);
      send_access(OP_RD_DATA, 14'h0000, 16'h0000);
      send_access(OP_WR_DATA, 14'h0055, 16'h0000);   // not 42h: stays in poll phase
      send_access(OP_WR_DATA, 14'h0042, 16'h0000);
      send_access(OP_WR_DATA, 14'h0000, 16'h0000);
      send_access(OP_WR_DATA, 14'h00FF, 16'h0000);
      repeat (5) send_access(OP_RD_DATA, 14'h0000, 16'hFFFF);
      send_access(OP_RD_STAT, 14'h0000, 16'h0000);
      send_access(OP_WR_DATA, 14'h0001, 16'h0000);
      send_access(OP_WR_CTRL, 14'h0002, 16'h0000);   // deselect, ready kept
      send_access(OP_RD_DATA, 14'h0000, 16'h0000);
      send_access(OP_RD_STAT, 14'h0000, 16'h0000);
      send_access(OP_WR_CTRL, 14'h0000, 16'h0000);

      while (applied_count < TargetItems) begin
         calm = ($urandom_range(0, 5) == 0);
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            poll_sequence();
         end else if (kind <= 7) begin
            // broken poll: handshake bytes in random order
            repeat ($urandom_range(3, 10)) begin
               if ($urandom_range(0, 2) == 0) send_random();
               else send_access(OP_WR_DATA, data_word(pick_byte()), rand_buttons());
            end
         end else if (kind == 8) begin
            send_access(OP_WR_CTRL, rand_word(), rand_buttons());
            send_access(OP_RD_CTRL, rand_word(), rand_buttons());
         end else begin
            repeat ($urandom_range(1, 8)) send_random();
         end
      end
      req_ch.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("joypad_serial_poll_responder_tb: PASS");
      end else begin
         $display("joypad_serial_poll_responder_tb: FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
design/jpsp_pkg.sv
design/jpsp_if.sv
design/jpsp_in_stage.sv
design/jpsp_core.sv
design/jpsp_out_stage.sv
design/joypad_serial_poll_responder.sv
bench/joypad_serial_poll_responder_tb.sv
